>>> hw/rtl/insphere_exact_sign_macros.svh
// Assertion macros for the insphere sign block
`ifndef INSPHERE_EXACT_SIGN_MACROS_SVH
`define INSPHERE_EXACT_SIGN_MACROS_SVH
`ifndef ASSERT_OFF
`define INSX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define INSX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define INSX_ASSERT_IMP(lbl, ante, cons, msg)
`define INSX_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/insx_pkg.sv
// Package: constants, instruction format and microprogram for the insphere block
`default_nettype none
package insx_pkg;

  localparam int COORD_BITS_DEF = 53;
  localparam int RF_DEPTH       = 26;
  localparam int PROG_LEN       = 40;

  typedef logic [4:0] rf_addr_t;
  typedef logic [5:0] pc_t;

  // difference vectors, point-major
  localparam rf_addr_t DAX = 5'd0;
  localparam rf_addr_t DAY = 5'd1;
  localparam rf_addr_t DAZ = 5'd2;
  localparam rf_addr_t DBX = 5'd3;
  localparam rf_addr_t DBY = 5'd4;
  localparam rf_addr_t DBZ = 5'd5;
  localparam rf_addr_t DCX = 5'd6;
  localparam rf_addr_t DCY = 5'd7;
  localparam rf_addr_t DCZ = 5'd8;
  localparam rf_addr_t DDX = 5'd9;
  localparam rf_addr_t DDY = 5'd10;
  localparam rf_addr_t DDZ = 5'd11;
  // xy minors
  localparam rf_addr_t R_AB = 5'd12;
  localparam rf_addr_t R_BC = 5'd13;
  localparam rf_addr_t R_CD = 5'd14;
  localparam rf_addr_t R_DA = 5'd15;
  localparam rf_addr_t R_AC = 5'd16;
  localparam rf_addr_t R_BD = 5'd17;
  // cofactors
  localparam rf_addr_t R_ABC = 5'd18;
  localparam rf_addr_t R_BCD = 5'd19;
  localparam rf_addr_t R_CDA = 5'd20;
  localparam rf_addr_t R_DAB = 5'd21;
  // squared norms
  localparam rf_addr_t R_N0 = 5'd22;
  localparam rf_addr_t R_N1 = 5'd23;
  localparam rf_addr_t R_N2 = 5'd24;
  localparam rf_addr_t R_N3 = 5'd25;

  localparam logic [1:0] SIGN_POS  = 2'b01;
  localparam logic [1:0] SIGN_NEG  = 2'b11;
  localparam logic [1:0] SIGN_ZERO = 2'b00;

  // one multiply-accumulate step: acc = (first ? 0 : acc) +/- rf[a] * rf[b]
  typedef struct packed {
    rf_addr_t a;
    rf_addr_t b;
    logic     neg;
    logic     first;
    logic     last;
    rf_addr_t dst;
  } instr_t;

  function automatic instr_t mk(input rf_addr_t a, input rf_addr_t b, input logic neg,
                                input logic first, input logic last, input rf_addr_t dst);
    instr_t i;
    i.a = a; i.b = b; i.neg = neg; i.first = first; i.last = last; i.dst = dst;
    return i;
  endfunction

  function automatic instr_t prog(input pc_t pc);
    instr_t i;
    unique case (pc)
      6'd0:  i = mk(DAX, DBY, 1'b0, 1'b1, 1'b0, R_AB);
      6'd1:  i = mk(DBX, DAY, 1'b1, 1'b0, 1'b1, R_AB);
      6'd2:  i = mk(DBX, DCY, 1'b0, 1'b1, 1'b0, R_BC);
      6'd3:  i = mk(DCX, DBY, 1'b1, 1'b0, 1'b1, R_BC);
      6'd4:  i = mk(DCX, DDY, 1'b0, 1'b1, 1'b0, R_CD);
      6'd5:  i = mk(DDX, DCY, 1'b1, 1'b0, 1'b1, R_CD);
      6'd6:  i = mk(DDX, DAY, 1'b0, 1'b1, 1'b0, R_DA);
      6'd7:  i = mk(DAX, DDY, 1'b1, 1'b0, 1'b1, R_DA);
      6'd8:  i = mk(DAX, DCY, 1'b0, 1'b1, 1'b0, R_AC);
      6'd9:  i = mk(DCX, DAY, 1'b1, 1'b0, 1'b1, R_AC);
      6'd10: i = mk(DBX, DDY, 1'b0, 1'b1, 1'b0, R_BD);
      6'd11: i = mk(DDX, DBY, 1'b1, 1'b0, 1'b1, R_BD);
      6'd12: i = mk(R_BC, DAZ, 1'b0, 1'b1, 1'b0, R_ABC);
      6'd13: i = mk(R_AC, DBZ, 1'b1, 1'b0, 1'b0, R_ABC);
      6'd14: i = mk(R_AB, DCZ, 1'b0, 1'b0, 1'b1, R_ABC);
      6'd15: i = mk(R_CD, DBZ, 1'b0, 1'b1, 1'b0, R_BCD);
      6'd16: i = mk(R_BD, DCZ, 1'b1, 1'b0, 1'b0, R_BCD);
      6'd17: i = mk(R_BC, DDZ, 1'b0, 1'b0, 1'b1, R_BCD);
      6'd18: i = mk(R_DA, DCZ, 1'b0, 1'b1, 1'b0, R_CDA);
      6'd19: i = mk(R_AC, DDZ, 1'b0, 1'b0, 1'b0, R_CDA);
      6'd20: i = mk(R_CD, DAZ, 1'b0, 1'b0, 1'b1, R_CDA);
      6'd21: i = mk(R_AB, DDZ, 1'b0, 1'b1, 1'b0, R_DAB);
      6'd22: i = mk(R_BD, DAZ, 1'b0, 1'b0, 1'b0, R_DAB);
      6'd23: i = mk(R_DA, DBZ, 1'b0, 1'b0, 1'b1, R_DAB);
      6'd24: i = mk(DAX, DAX, 1'b0, 1'b1, 1'b0, R_N0);
      6'd25: i = mk(DAY, DAY, 1'b0, 1'b0, 1'b0, R_N0);
      6'd26: i = mk(DAZ, DAZ, 1'b0, 1'b0, 1'b1, R_N0);
      6'd27: i = mk(DBX, DBX, 1'b0, 1'b1, 1'b0, R_N1);
      6'd28: i = mk(DBY, DBY, 1'b0, 1'b0, 1'b0, R_N1);
      6'd29: i = mk(DBZ, DBZ, 1'b0, 1'b0, 1'b1, R_N1);
      6'd30: i = mk(DCX, DCX, 1'b0, 1'b1, 1'b0, R_N2);
      6'd31: i = mk(DCY, DCY, 1'b0, 1'b0, 1'b0, R_N2);
      6'd32: i = mk(DCZ, DCZ, 1'b0, 1'b0, 1'b1, R_N2);
      6'd33: i = mk(DDX, DDX, 1'b0, 1'b1, 1'b0, R_N3);
      6'd34: i = mk(DDY, DDY, 1'b0, 1'b0, 1'b0, R_N3);
      6'd35: i = mk(DDZ, DDZ, 1'b0, 1'b0, 1'b1, R_N3);
      // final sum: the result stays in the accumulator
      6'd36: i = mk(R_ABC, R_N3, 1'b0, 1'b1, 1'b0, R_ABC);
      6'd37: i = mk(R_DAB, R_N2, 1'b1, 1'b0, 1'b0, R_ABC);
      6'd38: i = mk(R_CDA, R_N1, 1'b0, 1'b0, 1'b0, R_ABC);
      6'd39: i = mk(R_BCD, R_N0, 1'b1, 1'b0, 1'b0, R_ABC);
      default: i = mk(DAX, DAX, 1'b0, 1'b1, 1'b0, DAX);
    endcase
    return i;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/insx_rf.sv
// Wide register file: one write port, two registered read ports
`default_nettype none
module insx_rf import insx_pkg::*; #(
  parameter int W = 5 * COORD_BITS_DEF + 16
) (
  input  wire logic         clk,
  input  wire logic         we,
  input  wire rf_addr_t     waddr,
  input  wire logic [W-1:0] wdata,
  input  wire rf_addr_t     raddr_a,
  input  wire rf_addr_t     raddr_b,
  output logic [W-1:0]      rdata_a,
  output logic [W-1:0]      rdata_b
);

  logic [W-1:0] mem [RF_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

>>> hw/rtl/insx_mac.sv
// Bit-serial signed multiply-accumulate unit, one multiplier bit per cycle
`default_nettype none
module insx_mac import insx_pkg::*; #(
  parameter int W  = 5 * COORD_BITS_DEF + 16,
  parameter int MB = 2 * COORD_BITS_DEF + 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          neg,
  input  wire logic          first,
  input  wire logic [W-1:0]  a_val,
  input  wire logic [MB-1:0] b_val,
  output logic               busy,
  output logic [W-1:0]       acc
);

  localparam int CNT_W = $clog2(MB);

  logic [W-1:0]     areg;
  logic [MB-1:0]    breg;
  logic             subneg;
  logic [CNT_W-1:0] cnt;
  logic             top_bit;
  logic             do_sub;

  assign top_bit = (cnt == CNT_W'(MB - 1));
  // multiplier bit MB-1 carries negative weight
  assign do_sub  = subneg ^ top_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (top_bit) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      areg   <= a_val;
      breg   <= b_val;
      subneg <= neg;
      if (first) begin
        acc <= '0;
      end
    end else if (busy) begin
      if (breg[0]) begin
        acc <= do_sub ? (acc - areg) : (acc + areg);
      end
      areg <= {areg[W-2:0], 1'b0};
      breg <= {1'b0, breg[MB-1:1]};
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/insphere_exact_sign.sv
// Top level: exact insphere sign of five 3D points, bit-serial multiply-accumulate
// Points one to four: accept, then three store writes (x, y, z) in S_LOAD.
// The fifth point: accept, then 12 difference writes (each a read and a write-back),
// then 40 products on the bit-serial MAC, each a fetch, a launch and a run.
// Throughput: one point at a time; busy stays high until the work is done.
// Reset (rst, synchronous) clears the point count and control; the receiver cannot stall.
`default_nettype none
`include "insphere_exact_sign_macros.svh"
module insphere_exact_sign import insx_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COORD_BITS-1:0] point_x,
  input  wire logic [COORD_BITS-1:0] point_y,
  input  wire logic [COORD_BITS-1:0] point_z,
  output logic                       done,
  output logic signed [1:0]          sphere_sign
);

  // Word width covers the full determinant (needs 5*COORD_BITS+8 signed bits).
  localparam int W  = 5 * COORD_BITS + 16;
  // Multiplier operand width: a difference or a squared norm.
  localparam int MB = 2 * COORD_BITS + 4;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LOAD   = 7'b0000010,  // store x, y, z of points a..d
    S_DREAD  = 7'b0000100,  // read a stored coordinate
    S_DWRITE = 7'b0001000,  // write it back minus e
    S_FETCH  = 7'b0010000,  // issue operand reads
    S_OPLD   = 7'b0100000,  // launch the MAC
    S_RUN    = 7'b1000000   // MAC iterates
  } state_t;

  state_t                state;
  logic [2:0]            count;     // points held
  logic [1:0]            sub;       // coordinate index during load
  logic [3:0]            k;         // store index during differences
  logic [1:0]            m;         // k mod 3
  pc_t                   pc;
  logic [COORD_BITS-1:0] px, py, pz;
  instr_t                ins;

  logic                  rf_we;
  rf_addr_t              rf_waddr;
  logic [W-1:0]          rf_wdata;
  rf_addr_t              rf_ra, rf_rb;
  logic [W-1:0]          rd_a, rd_b;

  logic                  mac_start;
  logic                  mac_busy;
  logic [W-1:0]          acc;

  logic [COORD_BITS-1:0] load_coord, diff_coord;
  logic                  accept;
  logic                  op_done;

  assign ins     = prog(pc);
  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign op_done = (state == S_RUN) && !mac_busy;

  always_comb begin
    unique case (sub)
      2'd0:    load_coord = px;
      2'd1:    load_coord = py;
      default: load_coord = pz;
    endcase
    unique case (m)
      2'd0:    diff_coord = px;
      2'd1:    diff_coord = py;
      default: diff_coord = pz;
    endcase
  end

  // register file ports
  always_comb begin
    rf_we     = 1'b0;
    rf_waddr  = ins.dst;
    rf_wdata  = acc;
    rf_ra     = ins.a;
    rf_rb     = ins.b;
    mac_start = (state == S_OPLD);
    unique case (state)
      S_LOAD: begin
        rf_we    = 1'b1;
        rf_waddr = rf_addr_t'(count[1:0]) * 5'd3 + rf_addr_t'(sub);
        rf_wdata = W'(load_coord);
      end
      S_DREAD: begin
        rf_ra = rf_addr_t'(k);
      end
      S_DWRITE: begin
        rf_we    = 1'b1;
        rf_waddr = rf_addr_t'(k);
        rf_wdata = rd_a - W'(diff_coord);  // zero-extended operands, exact signed diff
      end
      S_RUN: begin
        rf_we = op_done && ins.last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      sub   <= '0;
      k     <= '0;
      m     <= '0;
      pc    <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            sub <= '0;
            k   <= '0;
            m   <= '0;
            // a count of four or more means this is the test point
            state <= count[2] ? S_DREAD : S_LOAD;
          end
        end
        S_LOAD: begin
          sub <= sub + 2'd1;
          if (sub == 2'd2) begin
            count <= count + 3'd1;
            state <= S_IDLE;
          end
        end
        S_DREAD: begin
          state <= S_DWRITE;
        end
        S_DWRITE: begin
          k <= k + 4'd1;
          m <= (m == 2'd2) ? 2'd0 : m + 2'd1;
          if (k == 4'd11) begin
            pc    <= '0;
            state <= S_FETCH;
          end else begin
            state <= S_DREAD;
          end
        end
        S_FETCH: begin
          state <= S_OPLD;
        end
        S_OPLD: begin
          state <= S_RUN;
        end
        S_RUN: begin
          if (!mac_busy) begin
            if (pc == pc_t'(PROG_LEN - 1)) begin
              done  <= 1'b1;
              count <= '0;
              state <= S_IDLE;
            end else begin
              pc    <= pc + pc_t'(1);
              state <= S_FETCH;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload capture: coordinates and the sign
  always_ff @(posedge clk) begin
    if (accept) begin
      px <= point_x;
      py <= point_y;
      pz <= point_z;
    end
    if (op_done && pc == pc_t'(PROG_LEN - 1)) begin
      if (acc[W-1]) begin
        sphere_sign <= SIGN_NEG;
      end else if (acc == '0) begin
        sphere_sign <= SIGN_ZERO;
      end else begin
        sphere_sign <= SIGN_POS;
      end
    end
  end

  insx_rf #(.W(W)) u_rf (
    .clk     (clk),
    .we      (rf_we),
    .waddr   (rf_waddr),
    .wdata   (rf_wdata),
    .raddr_a (rf_ra),
    .raddr_b (rf_rb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  insx_mac #(.W(W), .MB(MB)) u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .neg   (ins.neg),
    .first (ins.first),
    .a_val (rd_a),
    .b_val (rd_b[MB-1:0]),
    .busy  (mac_busy),
    .acc   (acc)
  );

  // a result transfer ends the test and frees the block
  `INSX_ASSERT_IMP(a_done_idle, done, !busy, "result while busy")
  `INSX_ASSERT_NXT(a_accept_busy, accept, busy, "accepted point did not raise busy")
  `INSX_ASSERT_IMP(a_done_after_work, done, $past(busy) && count == 3'd0, "stray result")
  `INSX_ASSERT_IMP(a_mac_only_run, mac_busy, state == S_RUN, "MAC active outside run")

endmodule
`default_nettype wire
